// File: design/ccp_pkg.sv
// shared types and constants for the cone frustum point projection core
// no dependencies; used by every module of the block
package ccp_pkg;

    // pipeline advance, driven by the top level, seen by every unit
    typedef struct packed {
        logic en;
    } pipe_ctl_t;

    // depth of the output buffer behind the last pipeline stage
    localparam int OUT_SLOTS = 2;

endpackage

// File: design/ccp_sqrt_pipe.sv
// pipelined integer square root, one result bit per stage, rounded to nearest
// depends on ccp_pkg (pipe_ctl_t); carries a side word and a valid bit alongside
module ccp_sqrt_pipe #(
    parameter int W      = 32,
    parameter int SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ccp_pkg::pipe_ctl_t  ctl,
    input  logic                vld_in,
    input  logic [2*W-1:0]      rad,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                vld_out,
    output logic [W-1:0]        root,
    output logic [SIDE_W-1:0]   side_out
);

    logic [W+1:0]      rem_reg  [1:W];
    logic [W-1:0]      root_reg [1:W];
    logic [2*W-1:0]    rad_reg  [1:W];
    logic [SIDE_W-1:0] side_reg [1:W];
    logic              vld_reg  [1:W];

    logic [W-1:0]      root_out_reg;
    logic [SIDE_W-1:0] side_out_reg;
    logic              vld_out_reg;

    for (genvar k = 1; k <= W; k++)
    begin : g_step
        logic [W+1:0]      rem_p;
        logic [W-1:0]      root_p;
        logic [2*W-1:0]    rad_p;
        logic [SIDE_W-1:0] side_p;
        logic              vld_p;
        logic [W+3:0]      t;
        logic [W+3:0]      trial;
        logic [W+3:0]      diff;
        logic              ge;

        if (k == 1)
        begin : g_first
            assign rem_p  = '0;
            assign root_p = '0;
            assign rad_p  = rad;
            assign side_p = side_in;
            assign vld_p  = vld_in;
        end
        else
        begin : g_next
            assign rem_p  = rem_reg[k-1];
            assign root_p = root_reg[k-1];
            assign rad_p  = rad_reg[k-1];
            assign side_p = side_reg[k-1];
            assign vld_p  = vld_reg[k-1];
        end

        // bring down the next bit pair and try root*4+1
        assign t     = {rem_p, rad_p[2*W-1 -: 2]};
        assign trial = {2'b00, root_p, 2'b01};
        assign ge    = (t >= trial);
        assign diff  = t - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (ctl.en)
                vld_reg[k] <= vld_p;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                rem_reg[k]  <= ge ? diff[W+1:0] : t[W+1:0];
                root_reg[k] <= {root_p[W-2:0], ge};
                rad_reg[k]  <= {rad_p[2*W-3:0], 2'b00};
                side_reg[k] <= side_p;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_out_reg <= 1'b0;
        else if (ctl.en)
            vld_out_reg <= vld_reg[W];
    end

    // remainder above the root means the value lies past root + 1/2
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            root_out_reg <= (rem_reg[W] > {2'b00, root_reg[W]}) ? root_reg[W] + 1'b1
                                                                : root_reg[W];
            side_out_reg <= side_reg[W];
        end
    end

    assign vld_out  = vld_out_reg;
    assign root     = root_out_reg;
    assign side_out = side_out_reg;

endmodule

// File: design/ccp_div_pipe.sv
// pipelined two-lane signed divider by a shared positive divisor, one quotient
// bit per stage, rounded to nearest with ties away from zero; depends on ccp_pkg
module ccp_div_pipe #(
    parameter int NW     = 101,
    parameter int DW     = 65,
    parameter int QW     = 34,
    parameter int SIDE_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ccp_pkg::pipe_ctl_t   ctl,
    input  logic                 vld_in,
    input  logic signed [NW-1:0] num0,
    input  logic signed [NW-1:0] num1,
    input  logic [DW-1:0]        den,
    input  logic [SIDE_W-1:0]    side_in,
    output logic                 vld_out,
    output logic signed [QW:0]   quo0,
    output logic signed [QW:0]   quo1,
    output logic [SIDE_W-1:0]    side_out
);

    localparam int RW = DW + 2;
    localparam int EW = NW + 2;
    localparam int HW = EW - QW;

    logic [1:0][RW-1:0] rem_reg  [0:QW];
    logic [1:0][QW-1:0] low_reg  [0:QW];
    logic [1:0][QW-1:0] q_reg    [0:QW];
    logic [1:0]         neg_reg  [0:QW];
    logic [DW:0]        dv_reg   [0:QW];
    logic [SIDE_W-1:0]  side_reg [0:QW];
    logic               vld_reg  [0:QW];

    logic signed [QW:0] quo0_reg;
    logic signed [QW:0] quo1_reg;
    logic [SIDE_W-1:0]  side_out_reg;
    logic               vld_out_reg;

    logic [1:0][NW-1:0] num_w;
    assign num_w[0] = num0;
    assign num_w[1] = num1;

    // set up |n|*2 + d over 2*d, top bits already reduced below the divisor
    logic [1:0][RW-1:0] rem_i;
    logic [1:0][QW-1:0] low_i;
    logic [1:0]         neg_i;

    for (genvar j = 0; j < 2; j++)
    begin : g_prep
        logic [NW-1:0] mag;
        logic [EW-1:0] dvd;
        logic [HW-1:0] hi;

        assign neg_i[j]  = num_w[j][NW-1];
        assign mag       = neg_i[j] ? (~num_w[j] + 1'b1) : num_w[j];
        assign dvd       = {1'b0, mag, 1'b0} + {{(EW-DW){1'b0}}, den};
        assign hi        = dvd[EW-1:QW];
        assign rem_i[j]  = RW'(hi);
        assign low_i[j]  = dvd[QW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (ctl.en)
            vld_reg[0] <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            rem_reg[0]  <= rem_i;
            low_reg[0]  <= low_i;
            q_reg[0]    <= '0;
            neg_reg[0]  <= neg_i;
            dv_reg[0]   <= {den, 1'b0};
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_step
        logic [1:0][RW-1:0] rem_n;
        logic [1:0][QW-1:0] low_n;
        logic [1:0][QW-1:0] q_n;

        for (genvar j = 0; j < 2; j++)
        begin : g_lane
            logic [RW:0] t;
            logic [RW:0] dvx;
            logic [RW:0] diff;
            logic        ge;

            assign t        = {rem_reg[k-1][j], low_reg[k-1][j][QW-1]};
            assign dvx      = {2'b00, dv_reg[k-1]};
            assign ge       = (t >= dvx);
            assign diff     = t - dvx;
            assign rem_n[j] = ge ? diff[RW-1:0] : t[RW-1:0];
            assign low_n[j] = {low_reg[k-1][j][QW-2:0], 1'b0};
            assign q_n[j]   = {q_reg[k-1][j][QW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (ctl.en)
                vld_reg[k] <= vld_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                rem_reg[k]  <= rem_n;
                low_reg[k]  <= low_n;
                q_reg[k]    <= q_n;
                neg_reg[k]  <= neg_reg[k-1];
                dv_reg[k]   <= dv_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_out_reg <= 1'b0;
        else if (ctl.en)
            vld_out_reg <= vld_reg[QW];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            quo0_reg     <= neg_reg[QW][0] ? -$signed({1'b0, q_reg[QW][0]})
                                           :  $signed({1'b0, q_reg[QW][0]});
            quo1_reg     <= neg_reg[QW][1] ? -$signed({1'b0, q_reg[QW][1]})
                                           :  $signed({1'b0, q_reg[QW][1]});
            side_out_reg <= side_reg[QW];
        end
    end

    assign vld_out  = vld_out_reg;
    assign quo0     = quo0_reg;
    assign quo1     = quo1_reg;
    assign side_out = side_out_reg;

endmodule

// File: design/cone_frustum_point_projection_core.sv
// top level: projects a 3-D point onto the generating line of a frustum face
// depends on ccp_pkg, ccp_sqrt_pipe and ccp_div_pipe
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_ready  | point_x/y/z, end_a_radius/height, end_b_radius/height
//  out     | out_valid / out_ready| foot_x/y/z, degenerate
//
// one word accepted per cycle while in_ready is high; the pipeline is built around
// the bit-per-stage square root and the two dividers
// reset clears every valid bit and the two-slot output buffer; payload is not reset
// the whole pipeline advances together; it halts only while both output slots are
// full, so a word may wait at the output while new words keep entering
module cone_frustum_point_projection_core #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    input  logic [COORD_WIDTH-2:0]        end_a_radius,
    input  logic signed [COORD_WIDTH-1:0] end_a_height,
    input  logic [COORD_WIDTH-2:0]        end_b_radius,
    input  logic signed [COORD_WIDTH-1:0] end_b_height,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] foot_x,
    output logic signed [COORD_WIDTH-1:0] foot_y,
    output logic signed [COORD_WIDTH-1:0] foot_z,
    output logic                          degenerate
);

    localparam int W    = COORD_WIDTH;
    localparam int DW1  = 2*W + 1;   // squared node distance
    localparam int NW1  = 3*W + 5;   // projection numerator times direction
    localparam int QW1  = W + 2;
    localparam int RSW  = W + 3;     // foot radius and height
    localparam int NW2  = 2*W + 3;   // foot radius times point coordinate
    localparam int QW2  = W + 3;
    localparam int OW   = W + 4;
    localparam int FW   = 3*W + 1;   // output buffer entry
    localparam int S3W  = 5*W - 1 + 2*(W+1) + 2*DW1;
    localparam int D1W  = 4*W - 1 + W + 1;
    localparam int D2W  = 2*RSW + 2;

    localparam logic signed [OW-1:0] SAT_HI = {{(OW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [OW-1:0] SAT_LO = {{(OW-W+1){1'b1}}, {(W-1){1'b0}}};

    ccp_pkg::pipe_ctl_t ctl;
    logic               pipe_en;

    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign pipe_en  = (cnt_reg != 2'(ccp_pkg::OUT_SLOTS));
    assign ctl.en   = pipe_en;
    assign in_ready = pipe_en;

    function automatic logic [W-1:0] sat(input logic signed [OW-1:0] a);
        logic signed [OW-1:0] r;
        r = a;
        if (a > SAT_HI)
            r = SAT_HI;
        else if (a < SAT_LO)
            r = SAT_LO;
        return r[W-1:0];
    endfunction

    // ---------------- stage 1: input registers
    logic                s1_v_reg;
    logic signed [W-1:0] s1_x_reg, s1_y_reg, s1_z_reg, s1_za_reg, s1_zb_reg;
    logic [W-2:0]        s1_ra_reg, s1_rb_reg;

    // ---------------- stage 2: squares of the point, node differences
    logic                  s2_v_reg;
    logic signed [W-1:0]   s2_x_reg, s2_y_reg, s2_z_reg, s2_za_reg;
    logic [W-2:0]          s2_ra_reg;
    logic signed [W:0]     s2_dr_reg, s2_dz_reg;
    logic signed [2*W-1:0] s2_xx_reg, s2_yy_reg;

    // ---------------- stage 3: radius squared, node direction squares
    logic                  s3_v_reg;
    logic signed [W-1:0]   s3_x_reg, s3_y_reg, s3_z_reg, s3_za_reg;
    logic [W-2:0]          s3_ra_reg;
    logic signed [W:0]     s3_dr_reg, s3_dz_reg;
    logic [2*W-1:0]        s3_s_reg;
    logic [DW1-1:0]        s3_drr_reg, s3_dzz_reg;
    logic signed [2*W+1:0] drr_w, dzz_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    assign drr_w = s2_dr_reg * s2_dr_reg;
    assign dzz_w = s2_dz_reg * s2_dz_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s1_x_reg   <= point_x;
            s1_y_reg   <= point_y;
            s1_z_reg   <= point_z;
            s1_ra_reg  <= end_a_radius;
            s1_za_reg  <= end_a_height;
            s1_rb_reg  <= end_b_radius;
            s1_zb_reg  <= end_b_height;

            s2_x_reg   <= s1_x_reg;
            s2_y_reg   <= s1_y_reg;
            s2_z_reg   <= s1_z_reg;
            s2_ra_reg  <= s1_ra_reg;
            s2_za_reg  <= s1_za_reg;
            s2_dr_reg  <= $signed({2'b00, s1_rb_reg}) - $signed({2'b00, s1_ra_reg});
            s2_dz_reg  <= {s1_zb_reg[W-1], s1_zb_reg} - {s1_za_reg[W-1], s1_za_reg};
            s2_xx_reg  <= s1_x_reg * s1_x_reg;
            s2_yy_reg  <= s1_y_reg * s1_y_reg;

            s3_x_reg   <= s2_x_reg;
            s3_y_reg   <= s2_y_reg;
            s3_z_reg   <= s2_z_reg;
            s3_ra_reg  <= s2_ra_reg;
            s3_za_reg  <= s2_za_reg;
            s3_dr_reg  <= s2_dr_reg;
            s3_dz_reg  <= s2_dz_reg;
            s3_s_reg   <= $unsigned(s2_xx_reg) + $unsigned(s2_yy_reg);
            s3_drr_reg <= drr_w[DW1-1:0];
            s3_dzz_reg <= dzz_w[DW1-1:0];
        end
    end

    // ---------------- cylindrical radius of the point
    logic                sq_v;
    logic [W-1:0]        sq_wr;
    logic [S3W-1:0]      sq_side;
    logic signed [W-1:0] q_x, q_y, q_z, q_za;
    logic [W-2:0]        q_ra;
    logic signed [W:0]   q_dr, q_dz;
    logic [DW1-1:0]      q_drr, q_dzz;

    ccp_sqrt_pipe #(
        .W      (W),
        .SIDE_W (S3W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .vld_in   (s3_v_reg),
        .rad      (s3_s_reg),
        .side_in  ({s3_x_reg, s3_y_reg, s3_z_reg, s3_ra_reg, s3_za_reg,
                    s3_dr_reg, s3_dz_reg, s3_drr_reg, s3_dzz_reg}),
        .vld_out  (sq_v),
        .root     (sq_wr),
        .side_out (sq_side)
    );

    assign {q_x, q_y, q_z, q_ra, q_za, q_dr, q_dz, q_drr, q_dzz} = sq_side;

    // ---------------- stages 4 to 8: projection numerator and its products
    logic                  s4_v_reg, s5_v_reg, s6_v_reg, s7_v_reg, s8_v_reg;
    logic signed [W-1:0]   s4_x_reg, s4_y_reg, s4_za_reg;
    logic [W-2:0]          s4_ra_reg;
    logic signed [W:0]     s4_dr_reg, s4_dz_reg, s4_pr_reg, s4_pz_reg;
    logic [DW1-1:0]        s4_d_reg;
    logic [W-1:0]          s4_wr_reg;

    logic signed [W-1:0]   s5_x_reg, s5_y_reg, s5_za_reg;
    logic [W-2:0]          s5_ra_reg;
    logic signed [W:0]     s5_dr_reg, s5_dz_reg;
    logic [DW1-1:0]        s5_d_reg;
    logic [W-1:0]          s5_wr_reg;
    logic signed [2*W+1:0] s5_m1_reg, s5_m2_reg;

    logic signed [W-1:0]   s6_x_reg, s6_y_reg, s6_za_reg;
    logic [W-2:0]          s6_ra_reg;
    logic signed [W:0]     s6_dr_reg, s6_dz_reg;
    logic [DW1-1:0]        s6_d_reg;
    logic [W-1:0]          s6_wr_reg;
    logic signed [2*W+2:0] s6_n_reg;

    logic signed [W-1:0]   s7_x_reg, s7_y_reg, s7_za_reg;
    logic [W-2:0]          s7_ra_reg;
    logic [DW1-1:0]        s7_d_reg;
    logic [W-1:0]          s7_wr_reg;
    logic signed [2*W+3:0] s7_hr_reg, s7_hz_reg;
    logic signed [2*W+1:0] s7_lr_reg, s7_lz_reg;

    logic signed [W-1:0]   s8_x_reg, s8_y_reg, s8_za_reg;
    logic [W-2:0]          s8_ra_reg;
    logic [DW1-1:0]        s8_d_reg;
    logic [W-1:0]          s8_wr_reg;
    logic                  s8_deg_reg;
    logic signed [NW1-1:0] s8_nr_reg, s8_nz_reg;

    logic signed [W+2:0]   n_hi;
    logic signed [W:0]     n_lo;

    // numerator split at bit W so each product stays near one word wide
    assign n_hi = s6_n_reg[2*W+2:W];
    assign n_lo = $signed({1'b0, s6_n_reg[W-1:0]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
            s7_v_reg <= 1'b0;
            s8_v_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s4_v_reg <= sq_v;
            s5_v_reg <= s4_v_reg;
            s6_v_reg <= s5_v_reg;
            s7_v_reg <= s6_v_reg;
            s8_v_reg <= s7_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s4_x_reg   <= q_x;
            s4_y_reg   <= q_y;
            s4_ra_reg  <= q_ra;
            s4_za_reg  <= q_za;
            s4_dr_reg  <= q_dr;
            s4_dz_reg  <= q_dz;
            s4_d_reg   <= q_drr + q_dzz;
            s4_wr_reg  <= sq_wr;
            s4_pr_reg  <= $signed({1'b0, sq_wr}) - $signed({2'b00, q_ra});
            s4_pz_reg  <= {q_z[W-1], q_z} - {q_za[W-1], q_za};

            s5_x_reg   <= s4_x_reg;
            s5_y_reg   <= s4_y_reg;
            s5_ra_reg  <= s4_ra_reg;
            s5_za_reg  <= s4_za_reg;
            s5_dr_reg  <= s4_dr_reg;
            s5_dz_reg  <= s4_dz_reg;
            s5_d_reg   <= s4_d_reg;
            s5_wr_reg  <= s4_wr_reg;
            s5_m1_reg  <= s4_pr_reg * s4_dr_reg;
            s5_m2_reg  <= s4_pz_reg * s4_dz_reg;

            s6_x_reg   <= s5_x_reg;
            s6_y_reg   <= s5_y_reg;
            s6_ra_reg  <= s5_ra_reg;
            s6_za_reg  <= s5_za_reg;
            s6_dr_reg  <= s5_dr_reg;
            s6_dz_reg  <= s5_dz_reg;
            s6_d_reg   <= s5_d_reg;
            s6_wr_reg  <= s5_wr_reg;
            s6_n_reg   <= {s5_m1_reg[2*W+1], s5_m1_reg} + {s5_m2_reg[2*W+1], s5_m2_reg};

            s7_x_reg   <= s6_x_reg;
            s7_y_reg   <= s6_y_reg;
            s7_ra_reg  <= s6_ra_reg;
            s7_za_reg  <= s6_za_reg;
            s7_d_reg   <= s6_d_reg;
            s7_wr_reg  <= s6_wr_reg;
            s7_hr_reg  <= n_hi * s6_dr_reg;
            s7_hz_reg  <= n_hi * s6_dz_reg;
            s7_lr_reg  <= n_lo * s6_dr_reg;
            s7_lz_reg  <= n_lo * s6_dz_reg;

            s8_x_reg   <= s7_x_reg;
            s8_y_reg   <= s7_y_reg;
            s8_ra_reg  <= s7_ra_reg;
            s8_za_reg  <= s7_za_reg;
            s8_d_reg   <= s7_d_reg;
            s8_wr_reg  <= s7_wr_reg;
            s8_deg_reg <= (s7_d_reg == '0);
            s8_nr_reg  <= {s7_hr_reg[2*W+3], s7_hr_reg, {W{1'b0}}}
                        + {{(W+3){s7_lr_reg[2*W+1]}}, s7_lr_reg};
            s8_nz_reg  <= {s7_hz_reg[2*W+3], s7_hz_reg, {W{1'b0}}}
                        + {{(W+3){s7_lz_reg[2*W+1]}}, s7_lz_reg};
        end
    end

    // ---------------- foot parameter along the face
    logic                d1_v;
    logic signed [QW1:0] d1_qr, d1_qz;
    logic [D1W-1:0]      d1_side;
    logic signed [W-1:0] e_x, e_y, e_za;
    logic [W-2:0]        e_ra;
    logic [W-1:0]        e_wr;
    logic                e_deg;

    ccp_div_pipe #(
        .NW     (NW1),
        .DW     (DW1),
        .QW     (QW1),
        .SIDE_W (D1W)
    ) u_div_line (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .vld_in   (s8_v_reg),
        .num0     (s8_nr_reg),
        .num1     (s8_nz_reg),
        .den      (s8_d_reg),
        .side_in  ({s8_x_reg, s8_y_reg, s8_ra_reg, s8_za_reg, s8_wr_reg, s8_deg_reg}),
        .vld_out  (d1_v),
        .quo0     (d1_qr),
        .quo1     (d1_qz),
        .side_out (d1_side)
    );

    assign {e_x, e_y, e_ra, e_za, e_wr, e_deg} = d1_side;

    // ---------------- stages 9 and 10: foot in the rz plane, rotate back
    logic                  s9_v_reg, s10_v_reg;
    logic signed [W-1:0]   s9_x_reg, s9_y_reg;
    logic [W-1:0]          s9_wr_reg, s10_wr_reg;
    logic                  s9_deg_reg, s10_deg_reg, s10_axis_reg;
    logic signed [RSW-1:0] s9_rs_reg, s9_zs_reg, s10_rs_reg, s10_zs_reg;
    logic signed [NW2-1:0] s10_px_reg, s10_py_reg;
    logic signed [RSW-1:0] ra_ext, za_ext;

    assign ra_ext = $signed({4'b0000, e_ra});
    assign za_ext = {{3{e_za[W-1]}}, e_za};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s9_v_reg  <= 1'b0;
            s10_v_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s9_v_reg  <= d1_v;
            s10_v_reg <= s9_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s9_x_reg     <= e_x;
            s9_y_reg     <= e_y;
            s9_wr_reg    <= e_wr;
            s9_deg_reg   <= e_deg;
            s9_rs_reg    <= e_deg ? ra_ext : ra_ext + d1_qr;
            s9_zs_reg    <= e_deg ? za_ext : za_ext + d1_qz;

            s10_wr_reg   <= s9_wr_reg;
            s10_axis_reg <= (s9_wr_reg == '0);
            s10_deg_reg  <= s9_deg_reg;
            s10_rs_reg   <= s9_rs_reg;
            s10_zs_reg   <= s9_zs_reg;
            s10_px_reg   <= s9_rs_reg * s9_x_reg;
            s10_py_reg   <= s9_rs_reg * s9_y_reg;
        end
    end

    logic                  d2_v;
    logic signed [QW2:0]   d2_qx, d2_qy;
    logic [D2W-1:0]        d2_side;
    logic signed [RSW-1:0] f_rs, f_zs;
    logic                  f_axis, f_deg;

    ccp_div_pipe #(
        .NW     (NW2),
        .DW     (W),
        .QW     (QW2),
        .SIDE_W (D2W)
    ) u_div_azim (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .vld_in   (s10_v_reg),
        .num0     (s10_px_reg),
        .num1     (s10_py_reg),
        .den      (s10_wr_reg),
        .side_in  ({s10_rs_reg, s10_zs_reg, s10_axis_reg, s10_deg_reg}),
        .vld_out  (d2_v),
        .quo0     (d2_qx),
        .quo1     (d2_qy),
        .side_out (d2_side)
    );

    assign {f_rs, f_zs, f_axis, f_deg} = d2_side;

    // ---------------- stage 11: select, saturate
    logic                s11_v_reg;
    logic signed [W-1:0] s11_fx_reg, s11_fy_reg, s11_fz_reg;
    logic                s11_deg_reg;
    logic signed [OW-1:0] rs_ow, zs_ow;

    assign rs_ow = {f_rs[RSW-1], f_rs};
    assign zs_ow = {f_zs[RSW-1], f_zs};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s11_v_reg <= 1'b0;
        else if (pipe_en)
            s11_v_reg <= d2_v;
    end

    // on the axis the azimuth is zero: foot_x is the foot radius itself
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s11_fx_reg  <= sat(f_axis ? rs_ow : d2_qx);
            s11_fy_reg  <= sat(f_axis ? '0 : d2_qy);
            s11_fz_reg  <= sat(zs_ow);
            s11_deg_reg <= f_deg;
        end
    end

    // ---------------- two-slot output buffer
    logic [FW-1:0] buf_reg [0:1];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;

    assign push = s11_v_reg && pipe_en;
    assign pop  = (cnt_reg != 2'd0) && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= {s11_fx_reg, s11_fy_reg, s11_fz_reg, s11_deg_reg};
    end

    assign out_valid = (cnt_reg != 2'd0);
    assign {foot_x, foot_y, foot_z, degenerate} = buf_reg[rd_ptr_reg];

    // ---------------- checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(ccp_pkg::OUT_SLOTS))
        else $error("output buffer overfilled");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(s11_v_reg) && $stable(s11_fx_reg) && $stable(s11_fz_reg))
        else $error("last stage changed during a stall");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd1 && out_ready && !push) |=> !out_valid)
        else $error("output word repeated after delivery");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("buffer pointers disagree with fill count");

endmodule

// File: verif/tb_top.sv
// self-checking testbench for cone_frustum_point_projection_core
// depends on the core and ccp_pkg; exact wide-integer foot prediction, random idling both sides
`timescale 1ns / 100ps

module tb_top;

    localparam int CW = 32;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 3 * CW + 22 + 40;
    localparam int RANDOM_WORDS = 430;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [CW-1:0] pz;
        logic [CW-2:0]        ra;
        logic signed [CW-1:0] za;
        logic [CW-2:0]        rb;
        logic signed [CW-1:0] zb;
        bit                   wait_drain;
        bit                   quiet;
    } query_t;

    typedef struct {
        logic signed [CW-1:0] fx;
        logic signed [CW-1:0] fy;
        logic signed [CW-1:0] fz;
        logic                 deg;
    } foot_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic [CW-2:0]        end_a_radius;
    logic signed [CW-1:0] end_a_height;
    logic [CW-2:0]        end_b_radius;
    logic signed [CW-1:0] end_b_height;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [CW-1:0] foot_x;
    logic signed [CW-1:0] foot_y;
    logic signed [CW-1:0] foot_z;
    logic                 degenerate;

    query_t pending_queries[$];
    foot_t  expected_feet[$];
    query_t current_query;
    int     send_gap;
    int     recv_stall;
    bit     quiet_phase;
    int     errors;
    int     words_sent;
    int     feet_checked;
    int     degenerate_seen;
    int     cycles;

    cone_frustum_point_projection_core #(.COORD_WIDTH(CW)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .end_a_radius (end_a_radius),
        .end_a_height (end_a_height),
        .end_b_radius (end_b_radius),
        .end_b_height (end_b_height),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .foot_x       (foot_x),
        .foot_y       (foot_y),
        .foot_z       (foot_z),
        .degenerate   (degenerate)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // rounded to nearest, ties away from zero
    function automatic wide_t div_nearest(wide_t n, wide_t d);
        wide_t an;
        wide_t ad;
        wide_t q;
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        q = (2 * an + ad) / (2 * ad);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic wide_t sqrt_nearest(wide_t n);
        wide_t r;
        wide_t c;
        r = 0;
        for (int i = 40; i >= 0; i--)
        begin
            c = r | (wide_t'(1) <<< i);
            if (c * c <= n)
                r = c;
        end
        if (n - r * r > r)
            r = r + 1;
        return r;
    endfunction

    function automatic logic signed [CW-1:0] clamp_coord(wide_t v);
        if (v > 256'sh7fffffff)
            return 32'sh7fffffff;
        if (v < -256'sh80000000)
            return 32'sh80000000;
        return v[CW-1:0];
    endfunction

    function automatic foot_t project_foot(query_t q);
        wide_t wx, wy, wz, ra, za, rb, zb;
        wide_t wr, dr, dz, den, num, rs, zs, fx, fy;
        foot_t f;
        wx = q.px;
        wy = q.py;
        wz = q.pz;
        ra = $signed({1'b0, q.ra});
        rb = $signed({1'b0, q.rb});
        za = q.za;
        zb = q.zb;
        wr = sqrt_nearest(wx * wx + wy * wy);
        dr = rb - ra;
        dz = zb - za;
        den = dr * dr + dz * dz;
        rs = ra;
        zs = za;
        f.deg = 1'b1;
        if (den != 0)
        begin
            num = (wr - ra) * dr + (wz - za) * dz;
            rs = ra + div_nearest(num * dr, den);
            zs = za + div_nearest(num * dz, den);
            f.deg = 1'b0;
        end
        // on the axis the azimuth is taken as zero
        if (wr == 0)
        begin
            fx = rs;
            fy = 0;
        end
        else
        begin
            fx = div_nearest(rs * wx, wr);
            fy = div_nearest(rs * wy, wr);
        end
        f.fx = clamp_coord(fx);
        f.fy = clamp_coord(fy);
        f.fz = clamp_coord(zs);
        return f;
    endfunction

    function automatic logic signed [CW-1:0] rand_coord(int kind);
        case (kind)
            0: return $urandom;
            1: return $signed($urandom_range(0, 2 * 1048576)) - 1048576;
            2: return $signed($urandom_range(0, 2 * 4096)) - 4096;
            default: return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
        endcase
    endfunction

    function automatic logic [CW-2:0] rand_radius(int kind);
        logic [CW-1:0] r;
        case (kind)
            0: r = $urandom;
            1: r = $urandom_range(0, 1048576);
            2: r = $urandom_range(0, 4096);
            default: r = ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h0;
        endcase
        return r[CW-2:0];
    endfunction

    function automatic query_t make_query(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                                          logic signed [CW-1:0] pz, logic [CW-2:0] ra,
                                          logic signed [CW-1:0] za, logic [CW-2:0] rb,
                                          logic signed [CW-1:0] zb);
        query_t q;
        q.px = px;
        q.py = py;
        q.pz = pz;
        q.ra = ra;
        q.za = za;
        q.rb = rb;
        q.zb = zb;
        q.wait_drain = 1'b0;
        q.quiet = 1'b0;
        return q;
    endfunction

    function automatic query_t random_query();
        query_t q;
        int k;
        k = ($urandom_range(0, 9) < 2) ? 0 : $urandom_range(1, 2);
        if ($urandom_range(0, 19) == 0)
            k = 3;
        q = make_query(rand_coord(k), rand_coord(k), rand_coord(k), rand_radius(k),
                       rand_coord(k), rand_radius(k), rand_coord(k));
        case ($urandom_range(0, 11))
            0: begin q.px = 0; q.py = 0; end
            1: begin q.rb = q.ra; q.zb = q.za; end
            2: q.rb = q.ra;
            3: q.zb = q.za;
            4: q.ra = 0;
            default: ;
        endcase
        return q;
    endfunction

    initial
    begin
        query_t q;
        // directed: extremes, axis points, coincident nodes, foot past the apex
        pending_queries.push_back(make_query(0, 0, 0, 0, 0, 0, 0));
        pending_queries.push_back(make_query(0, 0, 32'sh00050000, 31'h10000, 0, 31'h10000, 0));
        pending_queries.push_back(make_query(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                             31'h7fffffff, 32'sh7fffffff, 0, 32'sh80000000));
        pending_queries.push_back(make_query(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                             0, 32'sh80000000, 31'h7fffffff, 32'sh7fffffff));
        pending_queries.push_back(make_query(32'sh80000000, 0, 0, 31'h7fffffff, 0,
                                             31'h7fffffff, 32'sh7fffffff));
        pending_queries.push_back(make_query(0, 32'sh7fffffff, 0, 31'h7fffffff, 32'sh80000000,
                                             31'h7fffffff, 32'sh80000000));
        pending_queries.push_back(make_query(32'sh00030000, 32'sh00040000, 32'sh00020000,
                                             31'h10000, 0, 31'h30000, 32'sh00020000));
        pending_queries.push_back(make_query(32'sh00010000, 0, 32'sh00100000, 31'h20000, 0,
                                             31'h10000, 32'sh00010000));
        pending_queries.push_back(make_query(-32'sh00010000, 32'sh00020000, -32'sh00030000,
                                             31'h20000, 0, 31'h20000, 32'sh00040000));
        pending_queries.push_back(make_query(32'sh00050000, -32'sh00050000, 32'sh00010000,
                                             0, 0, 31'h40000, 0));
        pending_queries.push_back(make_query(0, 0, 32'sh00010000, 31'h10000, 0, 0,
                                             32'sh00010000));
        pending_queries.push_back(make_query(1, 0, 0, 0, 0, 1, 0));
        pending_queries.push_back(make_query(-1, -1, -1, 1, -1, 1, -1));
        pending_queries.push_back(make_query(32'sh55555555, 32'shaaaaaaaa, 32'sh55555555,
                                             31'h2aaaaaaa, 32'shaaaaaaaa, 31'h55555555,
                                             32'sh55555555));
        pending_queries.push_back(make_query(32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa,
                                             31'h55555555, 32'sh55555555, 31'h2aaaaaaa,
                                             32'shaaaaaaaa));
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            q = random_query();
            q.wait_drain = (i == 150);
            q.quiet = (i >= 280 && i < 340);
            pending_queries.push_back(q);
        end
        wait (rst_n === 1'b1);
        wait (pending_queries.size() == 0 && in_valid == 1'b0 && expected_feet.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("sent %0d words, checked %0d feet, %0d of them degenerate",
                 words_sent, feet_checked, degenerate_seen);
        $display("covered extremes, axis points, coincident and level nodes, random idling");
        if (errors == 0 && expected_feet.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            point_x      <= '0;
            point_y      <= '0;
            point_z      <= '0;
            end_a_radius <= '0;
            end_a_height <= '0;
            end_b_radius <= '0;
            end_b_height <= '0;
            send_gap     = 0;
            quiet_phase  = 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_feet.push_back(project_foot(current_query));
                words_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_queries.size() > 0 &&
                         !(pending_queries[0].wait_drain && expected_feet.size() > 0))
                begin
                    current_query = pending_queries.pop_front();
                    quiet_phase   = current_query.quiet;
                    point_x      <= current_query.px;
                    point_y      <= current_query.py;
                    point_z      <= current_query.pz;
                    end_a_radius <= current_query.ra;
                    end_a_height <= current_query.za;
                    end_b_radius <= current_query.rb;
                    end_b_height <= current_query.zb;
                    in_valid     <= 1'b1;
                    send_gap      = quiet_phase ? 0 : $urandom_range(0, 3);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        foot_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_feet.size() == 0)
                begin
                    $error("foot word with none expected");
                    errors++;
                end
                else
                begin
                    want = expected_feet.pop_front();
                    feet_checked++;
                    if (want.deg)
                        degenerate_seen++;
                    if (foot_x !== want.fx)
                    begin
                        $error("foot_x expected %0d got %0d", want.fx, foot_x);
                        errors++;
                    end
                    if (foot_y !== want.fy)
                    begin
                        $error("foot_y expected %0d got %0d", want.fy, foot_y);
                        errors++;
                    end
                    if (foot_z !== want.fz)
                    begin
                        $error("foot_z expected %0d got %0d", want.fz, foot_z);
                        errors++;
                    end
                    if (degenerate !== want.deg)
                    begin
                        $error("degenerate expected %0b got %0b", want.deg, degenerate);
                        errors++;
                    end
                end
                recv_stall = quiet_phase ? 0 : $urandom_range(0, 3);
                out_ready <= (recv_stall == 0);
            end
            else if (!out_ready)
            begin
                if (recv_stall > 0)
                    recv_stall--;
                out_ready <= (recv_stall == 0);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > TIMEOUT_CYCLES)
        begin
            $display("timeout with %0d feet outstanding", expected_feet.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
